// ----- rtl/vertex_delta_bitstream_decoder_assert.svh -----
// Assertion macros shared by the vertex delta bitstream decoder.
`ifndef VERTEX_DELTA_BITSTREAM_DECODER_ASSERT_SVH
`define VERTEX_DELTA_BITSTREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define VDBD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define VDBD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vdbd_pkg.sv -----
// Package with constants and shared types of the vertex delta bitstream decoder.
package vdbd_pkg;

    // Stream store geometry.
    localparam int STREAM_WORDS = 1024;
    localparam int POS_W        = 16;
    localparam int WORD_W       = 32;
    localparam int WIDX_W       = POS_W - 5;
    localparam int ADDR_W       = 10;

    // Even words sit in bank 0, odd words in bank 1.
    localparam int BANK0_DEPTH = (STREAM_WORDS + 1) / 2;
    localparam int BANK1_DEPTH = STREAM_WORDS / 2;
    localparam int BANK0_AW    = (BANK0_DEPTH > 1) ? $clog2(BANK0_DEPTH) : 1;
    localparam int BANK1_AW    = (BANK1_DEPTH > 1) ? $clog2(BANK1_DEPTH) : 1;

    // Item operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // A field width code of seven restarts that axis's accumulator.
    localparam logic [2:0] WIDTH_RESTART = 3'd7;

    // Two consecutive stream words, in reading order, with their in-range flags.
    typedef struct packed {
        logic [WORD_W-1:0] word_first;
        logic [WORD_W-1:0] word_second;
        logic              ok_first;
        logic              ok_second;
    } pair_t;

    // Fields unpacked for one vertex.
    typedef struct packed {
        logic signed [7:0] fx;
        logic signed [7:0] fy;
        logic signed [7:0] fz;
        logic [4:0]        nbits;
        logic              overrun;
    } fields_t;

endpackage

// ----- rtl/vdbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module vdbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/vdbd_store.sv -----
// Banked stream store that returns two consecutive words in one read.
module vdbd_store (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [vdbd_pkg::ADDR_W-1:0] wr_addr,
    input  logic [vdbd_pkg::WORD_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [vdbd_pkg::WIDX_W-1:0] rd_word,
    output vdbd_pkg::pair_t           rd_pair
);
    import vdbd_pkg::*;

    logic [WIDX_W-1:0]  wr_idx;
    logic               wr_in_range;
    logic [WIDX_W-1:0]  rd_word_next;
    logic [WIDX_W-1:0]  even_idx;
    logic [WIDX_W-1:0]  odd_idx;
    logic [WORD_W-1:0]  bank0_data;
    logic [WORD_W-1:0]  bank1_data;
    logic               par_reg;
    logic               ok_first_reg;
    logic               ok_second_reg;

    // Loads beyond the store are dropped.
    assign wr_idx      = WIDX_W'(wr_addr);
    assign wr_in_range = (32'(wr_addr) < STREAM_WORDS);

    // The second word wraps with the bit position; one of the pair is always even.
    assign rd_word_next = rd_word + WIDX_W'(1);
    assign even_idx     = rd_word[0] ? rd_word_next : rd_word;
    assign odd_idx      = rd_word[0] ? rd_word : rd_word_next;

    vdbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK0_DEPTH)
    ) u_bank0 (
        .aclk    (aclk),
        .wr_en   (wr_en && wr_in_range && !wr_idx[0]),
        .wr_addr (BANK0_AW'(wr_idx >> 1)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (BANK0_AW'(even_idx >> 1)),
        .rd_data (bank0_data)
    );

    vdbd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BANK1_DEPTH)
    ) u_bank1 (
        .aclk    (aclk),
        .wr_en   (wr_en && wr_in_range && wr_idx[0]),
        .wr_addr (BANK1_AW'(wr_idx >> 1)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (BANK1_AW'(odd_idx >> 1)),
        .rd_data (bank1_data)
    );

    // Ordering and range flags are registered alongside the read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            par_reg       <= 1'b0;
            ok_first_reg  <= 1'b0;
            ok_second_reg <= 1'b0;
        end else if (rd_en) begin
            par_reg       <= rd_word[0];
            ok_first_reg  <= (32'(rd_word) < STREAM_WORDS);
            ok_second_reg <= (32'(rd_word_next) < STREAM_WORDS);
        end
    end

    assign rd_pair.word_first  = par_reg ? bank1_data : bank0_data;
    assign rd_pair.word_second = par_reg ? bank0_data : bank1_data;
    assign rd_pair.ok_first    = ok_first_reg;
    assign rd_pair.ok_second   = ok_second_reg;

endmodule

// ----- rtl/vdbd_unpack.sv -----
// Extracts the three signed delta fields of one vertex from a word pair.
module vdbd_unpack (
    input  vdbd_pkg::pair_t           pair,
    input  logic [4:0]                offset,
    input  logic [vdbd_pkg::WORD_W-1:0] delta,
    output vdbd_pkg::fields_t         fields
);
    import vdbd_pkg::*;

    logic [2:0]  wx;
    logic [2:0]  wy;
    logic [2:0]  wz;
    logic [63:0] cat;
    logic [63:0] cat_shift;
    logic [23:0] win_x;
    logic [23:0] win_y;
    logic [23:0] win_z;
    logic [5:0]  end_pos;

    assign wx = delta[8:6];
    assign wy = delta[5:3];
    assign wz = delta[2:0];

    // Words beyond the store read as zero.
    assign cat = {pair.word_first & {WORD_W{pair.ok_first}},
                  pair.word_second & {WORD_W{pair.ok_second}}};

    // Align the bit position to the top of a 24-bit window.
    assign cat_shift = cat << offset;
    assign win_x     = cat_shift[63:40];
    assign win_y     = win_x << ({1'b0, wx} + 4'd1);
    assign win_z     = win_y << ({1'b0, wy} + 4'd1);

    // Each field is the top width+1 bits, sign-extended by an arithmetic shift.
    assign fields.fx = $signed(win_x[23:16]) >>> (3'd7 - wx);
    assign fields.fy = $signed(win_y[23:16]) >>> (3'd7 - wy);
    assign fields.fz = $signed(win_z[23:16]) >>> (3'd7 - wz);

    // Overrun when a word that is actually read lies beyond the store.
    assign fields.nbits   = 5'(wx) + 5'(wy) + 5'(wz) + 5'd3;
    assign end_pos        = {1'b0, offset} + {1'b0, fields.nbits};
    assign fields.overrun = !pair.ok_first || ((end_pos > 6'd32) && !pair.ok_second);

endmodule

// ----- rtl/vertex_delta_bitstream_decoder.sv -----
// Top level of the vertex delta bitstream decoder: sequencer, accumulators and output register.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | op, word_addr, word_data, delta_word, first_of_frame
//  m_      | out       | m_valid / m_ready   | coord_x, coord_y, coord_z, overrun
//
// A load transfer writes one bank of the stream store.
// A decode transfer reads both banks in its accept cycle; the S_CALC state then
// unpacks the fields and updates the accumulators, as the bank read is registered.
// After reset the store needs no clearing pass.
// A result waiting untaken in the output register stalls the next decode in S_CALC.
module vertex_delta_bitstream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [9:0]  s_word_addr,
    input  logic [31:0] s_word_data,
    input  logic [31:0] s_delta_word,
    input  logic        s_first_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_coord_x,
    output logic signed [31:0] m_coord_y,
    output logic signed [31:0] m_coord_z,
    output logic        m_overrun
);
    import vdbd_pkg::*;

    `include "vertex_delta_bitstream_decoder_assert.svh"

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t             state_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [31:0]        acc_x_reg;
    logic [31:0]        acc_y_reg;
    logic [31:0]        acc_z_reg;
    logic [31:0]        delta_reg;
    logic               m_valid_reg;
    logic [31:0]        coord_x_reg;
    logic [31:0]        coord_y_reg;
    logic [31:0]        coord_z_reg;
    logic               overrun_reg;

    logic               s_xfer;
    logic               load_xfer;
    logic               decode_xfer;
    logic [POS_W-1:0]   pos_start;
    pair_t              pair;
    fields_t            fields;
    logic               out_free;
    logic [31:0]        acc_x_next;
    logic [31:0]        acc_y_next;
    logic [31:0]        acc_z_next;
    logic [POS_W-1:0]   pos_next;

    // Input transfers are taken only between decodes.
    assign s_ready     = (state_reg == S_IDLE);
    assign s_xfer      = s_valid && s_ready;
    assign load_xfer   = s_xfer && (s_op == OP_LOAD);
    assign decode_xfer = s_xfer && (s_op == OP_DECODE);
    assign pos_start   = s_first_of_frame ? '0 : pos_reg;

    vdbd_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_xfer),
        .wr_addr (s_word_addr),
        .wr_data (s_word_data),
        .rd_en   (decode_xfer),
        .rd_word (pos_start[POS_W-1:5]),
        .rd_pair (pair)
    );

    vdbd_unpack u_unpack (
        .pair   (pair),
        .offset (pos_reg[4:0]),
        .delta  (delta_reg),
        .fields (fields)
    );

    // Accumulate field plus base; a width code of seven restarts the axis.
    always_comb begin
        acc_x_next = ((delta_reg[8:6] == WIDTH_RESTART) ? 32'd0 : acc_x_reg)
                   + {{24{fields.fx[7]}}, fields.fx} + 32'({delta_reg[31:25], 1'b0});
        acc_y_next = ((delta_reg[5:3] == WIDTH_RESTART) ? 32'd0 : acc_y_reg)
                   + {{24{fields.fy[7]}}, fields.fy} + 32'(delta_reg[24:17]);
        acc_z_next = ((delta_reg[2:0] == WIDTH_RESTART) ? 32'd0 : acc_z_reg)
                   + {{24{fields.fz[7]}}, fields.fz} + 32'(delta_reg[16:9]);
        pos_next   = pos_reg + POS_W'(fields.nbits);
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer, decode state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            acc_z_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A finished vertex fills the output register; otherwise a transfer empties it.
            if ((state_reg == S_CALC) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (decode_xfer) begin
                        delta_reg <= s_delta_word;
                        state_reg <= S_CALC;
                        if (s_first_of_frame) begin
                            pos_reg   <= '0;
                            acc_x_reg <= '0;
                            acc_y_reg <= '0;
                            acc_z_reg <= '0;
                        end
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        acc_x_reg   <= acc_x_next;
                        acc_y_reg   <= acc_y_next;
                        acc_z_reg   <= acc_z_next;
                        pos_reg     <= pos_next;
                        coord_x_reg <= acc_x_next;
                        coord_y_reg <= acc_z_next;
                        coord_z_reg <= acc_y_next;
                        overrun_reg <= fields.overrun;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_coord_x = $signed(coord_x_reg);
    assign m_coord_y = $signed(coord_y_reg);
    assign m_coord_z = $signed(coord_z_reg);
    assign m_overrun = overrun_reg;

    // A decode transfer always moves on to the unpack cycle.
    `VDBD_ASSERT_NEXT(a_decode_to_calc, aclk, aresetn, decode_xfer, state_reg == S_CALC, "decode transfer did not enter unpack cycle")
    // A pending, stalled result holds the unpack cycle.
    `VDBD_ASSERT_NEXT(a_calc_holds, aclk, aresetn, (state_reg == S_CALC) && m_valid_reg && !m_ready, state_reg == S_CALC, "unpack cycle overwrote a stalled result")
    // A load never makes a result appear.
    `VDBD_ASSERT_NEXT(a_load_silent, aclk, aresetn, load_xfer && !m_valid_reg, !m_valid_reg, "load transfer produced a result")
    // A new result only comes from the unpack cycle.
    `VDBD_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == S_CALC), "result raised outside the unpack cycle")

endmodule

// ----- dv/vertex_delta_bitstream_decoder_checker.sv -----
// Checker for the vertex delta bitstream decoder: tracks transfers, predicts vertices, compares.
module vertex_delta_bitstream_decoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [9:0]  s_word_addr,
    input  logic [31:0] s_word_data,
    input  logic [31:0] s_delta_word,
    input  logic        s_first_of_frame,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic signed [31:0] m_coord_x,
    input  logic signed [31:0] m_coord_y,
    input  logic signed [31:0] m_coord_z,
    input  logic        m_overrun,
    output int          mismatches,
    output int          pending_vertices,
    output int          vertices_checked,
    output int          overruns_seen
);
    import vdbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded vertex as it leaves the block, axes already swapped.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               overrun;
    } vertex_t;

    vertex_t expected_vertices [$];

    // Shadow of the decode state.
    logic [WORD_W-1:0] stream_copy [STREAM_WORDS];
    logic [POS_W-1:0]  read_pos;
    logic [31:0]       acc_x;
    logic [31:0]       acc_y;
    logic [31:0]       acc_z;

    // Pulls a signed field of nbits from the stream, MSB first, and sign-extends it.
    function automatic logic [31:0] take_field(input int nbits, inout logic past_end);
        logic [31:0]      raw;
        logic [POS_W-1:0] p;
        int               w;
        int               i;
        raw = '0;
        for (i = 0; i < nbits; i++) begin
            p = read_pos + POS_W'(i);
            w = int'(p >> 5);
            if (w < STREAM_WORDS) begin
                raw = {raw[30:0], stream_copy[w][31 - p[4:0]]};
            end else begin
                raw = {raw[30:0], 1'b0};
                past_end = 1'b1;
            end
        end
        read_pos = read_pos + POS_W'(nbits);
        if (raw[nbits-1]) begin
            raw = raw | ~((32'd1 << nbits) - 32'd1);
        end
        return raw;
    endfunction

    // Advances the shadow state by one vertex and returns the coordinates it yields.
    function automatic vertex_t decode_vertex(input logic [31:0] ctl, input logic new_frame);
        logic [2:0]  wx, wy, wz;
        logic [31:0] bx, by, bz;
        logic [31:0] fx, fy, fz;
        logic        past_end;
        vertex_t     v;
        if (new_frame) begin
            read_pos = '0;
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
        end
        wx = ctl[8:6];
        wy = ctl[5:3];
        wz = ctl[2:0];
        bx = {23'd0, ctl[31:25], 1'b0};
        by = {24'd0, ctl[24:17]};
        bz = {24'd0, ctl[16:9]};
        // The widest code starts the axis over from its base.
        if (wx == WIDTH_RESTART) acc_x = '0;
        if (wy == WIDTH_RESTART) acc_y = '0;
        if (wz == WIDTH_RESTART) acc_z = '0;
        past_end = 1'b0;
        fx = take_field(int'(wx) + 1, past_end);
        fy = take_field(int'(wy) + 1, past_end);
        fz = take_field(int'(wz) + 1, past_end);
        acc_x = acc_x + fx + bx;
        acc_y = acc_y + fy + by;
        acc_z = acc_z + fz + bz;
        v.x = acc_x;
        v.y = acc_z;
        v.z = acc_y;
        v.overrun = past_end;
        return v;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    // Results are compared before new decodes are queued: a result can never belong
    // to the decode accepted at the same edge.
    always @(posedge aclk) begin
        vertex_t want;
        if (!aresetn) begin
            expected_vertices.delete();
            read_pos = '0;
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
            mismatches = 0;
            vertices_checked = 0;
            overruns_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("%0t ns: unexpected result transfer, x %0d y %0d z %0d overrun %0b",
                             $time, m_coord_x, m_coord_y, m_coord_z, m_overrun);
                    mismatches++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("coord_x", want.x, m_coord_x);
                    check_field("coord_y", want.y, m_coord_y);
                    check_field("coord_z", want.z, m_coord_z);
                    check_field("overrun", {31'd0, want.overrun}, {31'd0, m_overrun});
                    vertices_checked++;
                    if (want.overrun) overruns_seen++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_op == OP_LOAD) begin
                    if (s_word_addr < STREAM_WORDS) stream_copy[s_word_addr] = s_word_data;
                end else begin
                    expected_vertices.push_back(decode_vertex(s_delta_word, s_first_of_frame));
                end
            end
        end
        pending_vertices = expected_vertices.size();
    end

endmodule

// ----- dv/vertex_delta_bitstream_decoder_test.sv -----
// Top of the vertex delta bitstream decoder testbench: clock, reset, stimulus and verdict.
module vertex_delta_bitstream_decoder_test;
    import vdbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MIXED_ITEMS = 1000;
    // The long frame carries the bit position through about two hundred stream words.
    localparam int SWEEP_BITS  = 6144;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [9:0]  s_word_addr;
    logic [31:0] s_word_data;
    logic [31:0] s_delta_word;
    logic        s_first_of_frame;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_coord_x;
    logic signed [31:0] m_coord_y;
    logic signed [31:0] m_coord_z;
    logic        m_overrun;

    int mismatches;
    int pending_vertices;
    int vertices_checked;
    int overruns_seen;

    // Stimulus bookkeeping: which words hold data and where the next field starts.
    bit               loaded [STREAM_WORDS];
    logic [POS_W-1:0] next_bit;
    int               frame_bits;
    int               loads_sent;
    int               decodes_sent;
    int               cycle_count;
    logic             calm;

    always #2 aclk = ~aclk;

    vertex_delta_bitstream_decoder uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_word_addr      (s_word_addr),
        .s_word_data      (s_word_data),
        .s_delta_word     (s_delta_word),
        .s_first_of_frame (s_first_of_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coord_x        (m_coord_x),
        .m_coord_y        (m_coord_y),
        .m_coord_z        (m_coord_z),
        .m_overrun        (m_overrun)
    );

    vertex_delta_bitstream_decoder_checker vertex_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_word_addr      (s_word_addr),
        .s_word_data      (s_word_data),
        .s_delta_word     (s_delta_word),
        .s_first_of_frame (s_first_of_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coord_x        (m_coord_x),
        .m_coord_y        (m_coord_y),
        .m_coord_z        (m_coord_z),
        .m_overrun        (m_overrun),
        .mismatches       (mismatches),
        .pending_vertices (pending_vertices),
        .vertices_checked (vertices_checked),
        .overruns_seen    (overruns_seen)
    );

    // Result side stalls at random, except during the calm stretch.
    always @(posedge aclk) begin
        if (calm) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) >= 6);
    end

    // Run watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] pack_ctl(input logic [22:0] bases, input logic [2:0] wx,
                                             input logic [2:0] wy, input logic [2:0] wz);
        return {bases, wx, wy, wz};
    endfunction

    // Mostly the widest fields, so the long frame covers the bit space quickly.
    function automatic logic [2:0] sweep_width();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : WIDTH_RESTART;
    endfunction

    // Presents one item and holds it until its transfer, with an occasional gap first.
    task automatic offer_item(input logic op, input logic [9:0] addr, input logic [31:0] data,
                              input logic [31:0] ctl, input logic new_frame);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 6) gap = $urandom_range(1, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_word_addr <= addr;
        s_word_data <= data;
        s_delta_word <= ctl;
        s_first_of_frame <= new_frame;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_word(input logic [9:0] addr, input logic [31:0] data);
        offer_item(OP_LOAD, addr, data, 32'($urandom), 1'($urandom));
        loaded[addr] = 1'b1;
        loads_sent++;
    endtask

    // Sends a decode, first loading any in-range word its fields would touch unwritten.
    task automatic send_vertex(input logic [31:0] ctl, input logic new_frame);
        logic [POS_W-1:0] first_bit;
        logic [POS_W-1:0] p;
        int               nbits;
        int               w;
        first_bit = new_frame ? '0 : next_bit;
        nbits = int'(ctl[8:6]) + int'(ctl[5:3]) + int'(ctl[2:0]) + 3;
        for (int i = 0; i < nbits; i++) begin
            p = first_bit + POS_W'(i);
            w = int'(p >> 5);
            if (w < STREAM_WORDS && !loaded[w]) send_word(ADDR_W'(w), $urandom);
        end
        offer_item(OP_DECODE, 10'($urandom), 32'($urandom), ctl, new_frame);
        next_bit = first_bit + POS_W'(nbits);
        frame_bits = new_frame ? nbits : frame_bits + nbits;
        decodes_sent++;
    endtask

    // Holds the input side idle until every outstanding vertex has come out.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_vertices != 0);
        @(posedge aclk);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op <= OP_LOAD;
        s_word_addr <= '0;
        s_word_data <= '0;
        s_delta_word <= '0;
        s_first_of_frame <= 1'b0;
        m_ready <= 1'b0;
        calm = 1'b0;
        next_bit = '0;
        frame_bits = 0;
        loads_sent = 0;
        decodes_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: stream patterns of all ones, all zeros, the sign extremes and alternating bits.
        send_word(10'd0, 32'hFFFF_FFFF);
        send_word(10'd1, 32'h0000_0000);
        send_word(10'd2, 32'h8000_0000);
        send_word(10'd3, 32'h7FFF_FFFF);
        send_word(10'd4, 32'hAAAA_AAAA);
        send_word(10'd1023, 32'hFFFF_FFFF);
        // Narrowest fields at a frame start, then the widest with maximum bases.
        send_vertex(pack_ctl(23'd0, 3'd0, 3'd0, 3'd0), 1'b1);
        send_vertex(pack_ctl('1, WIDTH_RESTART, WIDTH_RESTART, WIDTH_RESTART), 1'b0);
        send_vertex(32'hFFFF_FFFF, 1'b0);
        send_vertex(32'h0000_0000, 1'b0);
        // Mixed widths that straddle word boundaries and accumulate, with one restart of the y axis.
        send_vertex(pack_ctl(23'h2AAAAA, 3'd6, 3'd3, 3'd5), 1'b0);
        send_vertex(pack_ctl(23'h555555, 3'd5, 3'd6, 3'd4), 1'b0);
        send_vertex(pack_ctl(23'h7FFFFF, 3'd2, 3'd1, 3'd6), 1'b0);
        send_vertex(pack_ctl(23'h000001, 3'd4, WIDTH_RESTART, 3'd0), 1'b0);
        // Frame start with nonzero state behind it.
        send_vertex(pack_ctl(23'h123456, 3'd3, 3'd3, 3'd3), 1'b1);
        send_vertex(pack_ctl(23'h654321, 3'd1, 3'd5, WIDTH_RESTART), 1'b0);
        send_vertex(32'h0000_0000, 1'b1);
        send_vertex(pack_ctl('1, 3'd6, 3'd6, 3'd6), 1'b0);
        drain();

        // Random mix of loads and short frames, with a calm stretch and periodic drains.
        for (int n = 0; n < MIXED_ITEMS; n++) begin
            calm = (n >= 300 && n < 500);
            if (n % 250 == 249) drain();
            if ($urandom_range(0, 3) == 0) begin
                send_word(10'($urandom_range(0, STREAM_WORDS - 1)), $urandom);
            end else begin
                send_vertex($urandom, $urandom_range(0, 11) == 0);
            end
        end
        calm = 1'b0;

        // One long frame of mostly wide fields, loading each new word on the way.
        send_vertex(pack_ctl(23'($urandom), WIDTH_RESTART, WIDTH_RESTART, WIDTH_RESTART), 1'b1);
        while (frame_bits < SWEEP_BITS) begin
            send_vertex(pack_ctl(23'($urandom), sweep_width(), sweep_width(), sweep_width()),
                        1'b0);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Covered %0d stream word loads and %0d vertex decodes; %0d results checked.",
                 loads_sent, decodes_sent, vertices_checked);
        $display("%0d results read past the stream store; the long frame spanned %0d bits.",
                 overruns_seen, frame_bits);
        if (mismatches == 0 && pending_vertices == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vdbd_pkg.sv
rtl/vdbd_ram.sv
rtl/vdbd_store.sv
rtl/vdbd_unpack.sv
rtl/vertex_delta_bitstream_decoder.sv
dv/vertex_delta_bitstream_decoder_checker.sv
dv/vertex_delta_bitstream_decoder_test.sv
